/* rtl/core/mfpt_pkg.sv */
// Package: register map, function codes and prescale table of the MFP timer block.
package mfpt_pkg;

	typedef enum logic [2:0] {
		FN_READ   = 3'd0,
		FN_WRITE  = 3'd1,
		FN_TICK   = 3'd2,
		FN_VBLANK = 3'd3,
		FN_KBD    = 3'd4,
		FN_ACK    = 3'd5
	} func_t;

	localparam logic [4:0] R_GPIP  = 5'd0;
	localparam logic [4:0] R_AER   = 5'd1;
	localparam logic [4:0] R_IERA  = 5'd3;
	localparam logic [4:0] R_IERB  = 5'd4;
	localparam logic [4:0] R_IPRA  = 5'd5;
	localparam logic [4:0] R_IPRB  = 5'd6;
	localparam logic [4:0] R_ISRA  = 5'd7;
	localparam logic [4:0] R_ISRB  = 5'd8;
	localparam logic [4:0] R_IMRA  = 5'd9;
	localparam logic [4:0] R_IMRB  = 5'd10;
	localparam logic [4:0] R_VR    = 5'd11;
	localparam logic [4:0] R_TACR  = 5'd12;
	localparam logic [4:0] R_TBCR  = 5'd13;
	localparam logic [4:0] R_TCDCR = 5'd14;
	localparam logic [4:0] R_TADR  = 5'd15;
	localparam logic [4:0] R_TBDR  = 5'd16;
	localparam logic [4:0] R_TCDR  = 5'd17;
	localparam logic [4:0] R_TDDR  = 5'd18;
	localparam logic [4:0] R_RSR   = 5'd21;
	localparam logic [4:0] R_UDR   = 5'd23;

	localparam logic [7:0] VBLANK_BIT = 8'h10;
	localparam logic [7:0] KBD_BIT    = 8'h10;
	localparam logic [7:0] GPIP4_IRQ  = 8'h40;
	localparam logic [7:0] RX_FULL    = 8'h80;
	localparam logic [7:0] VR_MASK    = 8'hF0;
	localparam logic [7:0] GPIP_RESET = 8'hFF;

	localparam logic [7:0] MAX_RATIO = 8'd200;

	function automatic logic [7:0] divide_ratio(input logic [2:0] code);
		logic [7:0] r;
		case (code)
			3'd0:    r = 8'd0;
			3'd1:    r = 8'd4;
			3'd2:    r = 8'd10;
			3'd3:    r = 8'd16;
			3'd4:    r = 8'd50;
			3'd5:    r = 8'd64;
			3'd6:    r = 8'd100;
			3'd7:    r = 8'd200;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/mfpt_req_if.sv */
// Interface: request channel carrying one bus or event transaction.
interface mfpt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [4:0]  reg_index;
	logic [7:0]  data_byte;
	logic [11:0] cpu_cycles;
	logic        vblank_active;

	modport source (output valid, func, reg_index, data_byte, cpu_cycles, vblank_active,
		input ready);
	modport sink (input valid, func, reg_index, data_byte, cpu_cycles, vblank_active,
		output ready);
endinterface

/* rtl/core/mfpt_rsp_if.sv */
// Interface: response channel carrying one result transaction.
interface mfpt_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       vector_valid;
	logic [7:0] vector_number;
	logic       irq_pending;

	modport source (output valid, read_data, vector_valid, vector_number, irq_pending,
		input ready);
	modport sink (input valid, read_data, vector_valid, vector_number, irq_pending,
		output ready);
endinterface

/* rtl/core/multi_function_peripheral_timers_irq_unit.sv */
// Top level: MC68901-style register file, four interval timers and vectored IRQ controller.
// Timing: read, write, vblank, keyboard and acknowledge transactions give their result
//   in the cycle after acceptance. A tick steps each of the four timers in turn through its
//   prescale steps; one shared subtract/decrement unit walks the timers.
// Throughput: one non-tick item per cycle while the output is free; ready is low in a tick.
// Reset (arst_n, async): GPIP = 0xFF, all other registers, prescale accumulators and
//   timer counters cleared; no result held.
module multi_function_peripheral_timers_irq_unit #(
	parameter int NUM_REGS    = 24,
	parameter int CYCLE_SHIFT = 1
) (
	input logic clk,
	input logic arst_n,
	mfpt_req_if.sink   req,
	mfpt_rsp_if.source rsp
);
	import mfpt_pkg::*;

	typedef enum logic {ST_IDLE, ST_TICK} state_t;

	state_t      state_q;
	logic [7:0]  regs_q [NUM_REGS];
	logic [15:0] acc_q  [4];
	logic [7:0]  cnt_q  [4];
	logic [1:0]  t_q;          // timer being stepped
	logic [15:0] work_q;       // running accumulator of current timer
	logic [11:0] mc_q;         // cycle count of the tick, shifted right by CYCLE_SHIFT

	logic        out_valid_q;
	logic [7:0]  rd_q;
	logic        vv_q;
	logic [7:0]  vec_q;

	logic        out_free, accept, idx_ok;
	logic [11:0] mc;
	logic [7:0]  pa, pb, ratio, tdata, cnt_dec;
	logic [2:0]  code, pa_bit, pb_bit;
	logic        step, last;

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept = req.valid && req.ready;
	assign idx_ok = ({1'b0, req.reg_index} < 6'(NUM_REGS));
	assign mc = req.cpu_cycles >> CYCLE_SHIFT;

	assign pa = regs_q[R_IPRA] & regs_q[R_IMRA];
	assign pb = regs_q[R_IPRB] & regs_q[R_IMRB];

	// highest set bit of each masked pending group
	always_comb begin
		pa_bit = 3'd0;
		pb_bit = 3'd0;
		for (int b = 0; b < 8; b++) begin
			if (pa[b]) pa_bit = 3'(b);
			if (pb[b]) pb_bit = 3'(b);
		end
	end

	// timer selected by the sequencer
	always_comb begin
		case (t_q)
			2'd0:    code = regs_q[R_TACR][2:0];
			2'd1:    code = regs_q[R_TBCR][2:0];
			2'd2:    code = regs_q[R_TCDCR][6:4];
			default: code = regs_q[R_TCDCR][2:0];
		endcase
		tdata = regs_q[R_TADR + 5'(t_q)];
	end
	assign ratio   = divide_ratio(code);
	assign step    = (ratio != 8'd0) && (work_q >= {8'd0, ratio});
	assign last    = !step && (t_q == 2'd3);
	assign cnt_dec = cnt_q[t_q] - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			rd_q        <= '0;
			vv_q        <= 1'b0;
			vec_q       <= '0;
			t_q         <= '0;
			work_q      <= '0;
			mc_q        <= '0;
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
			regs_q[R_GPIP] <= GPIP_RESET;
			for (int i = 0; i < 4; i++) begin
				acc_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_q        <= '0;
						vv_q        <= 1'b0;
						vec_q       <= '0;
						out_valid_q <= 1'b1;
						case (req.func)
							FN_READ: begin
								if (idx_ok) rd_q <= regs_q[req.reg_index];
							end
							FN_WRITE: begin
								if (idx_ok) begin
									case (req.reg_index)
										R_IPRA, R_IPRB, R_ISRA, R_ISRB:
											regs_q[req.reg_index] <=
												regs_q[req.reg_index] & req.data_byte;
										R_TADR, R_TBDR, R_TCDR, R_TDDR: begin
											regs_q[req.reg_index] <= req.data_byte;
											cnt_q[2'(req.reg_index - R_TADR)] <= req.data_byte;
										end
										R_GPIP: ;
										default: regs_q[req.reg_index] <= req.data_byte;
									endcase
								end
							end
							FN_TICK: begin
								if (mc != 12'd0) begin
									out_valid_q <= 1'b0;
									mc_q        <= mc;
									t_q         <= 2'd0;
									work_q      <= acc_q[0] + {4'd0, mc};
									state_q     <= ST_TICK;
								end
							end
							FN_VBLANK: begin
								regs_q[R_GPIP] <= req.vblank_active ?
									(regs_q[R_GPIP] & ~VBLANK_BIT) :
									(regs_q[R_GPIP] | VBLANK_BIT);
								// edge when level flips; AER picks the active edge
								if ((regs_q[R_GPIP][4] == req.vblank_active) &&
									(regs_q[R_AER][4] == !req.vblank_active) &&
									regs_q[R_IERB][6])
									regs_q[R_IPRB] <= regs_q[R_IPRB] | GPIP4_IRQ;
							end
							FN_KBD: begin
								regs_q[R_UDR] <= req.data_byte;
								regs_q[R_RSR] <= regs_q[R_RSR] | RX_FULL;
								if (regs_q[R_IERA][4])
									regs_q[R_IPRA] <= regs_q[R_IPRA] | KBD_BIT;
							end
							FN_ACK: begin
								if (pa != 8'd0) begin
									regs_q[R_IPRA][pa_bit] <= 1'b0;
									regs_q[R_ISRA][pa_bit] <= 1'b1;
									vv_q  <= 1'b1;
									// group A channels are 8..15
									vec_q <= (regs_q[R_VR] & VR_MASK) | {4'd0, 1'b1, pa_bit};
								end else if (pb != 8'd0) begin
									regs_q[R_IPRB][pb_bit] <= 1'b0;
									regs_q[R_ISRB][pb_bit] <= 1'b1;
									vv_q  <= 1'b1;
									vec_q <= (regs_q[R_VR] & VR_MASK) | {5'd0, pb_bit};
								end
							end
							default: ;
						endcase
					end
				end
				ST_TICK: begin
					if (step) begin
						work_q <= work_q - {8'd0, ratio};
						if (cnt_dec == 8'd0) begin
							cnt_q[t_q] <= tdata;
							case (t_q)
								2'd0: if (regs_q[R_IERA][5]) regs_q[R_IPRA][5] <= 1'b1;
								2'd1: if (regs_q[R_IERA][0]) regs_q[R_IPRA][0] <= 1'b1;
								2'd2: if (regs_q[R_IERB][5]) regs_q[R_IPRB][5] <= 1'b1;
								default: if (regs_q[R_IERB][4]) regs_q[R_IPRB][4] <= 1'b1;
							endcase
						end else begin
							cnt_q[t_q] <= cnt_dec;
						end
					end else if (!last) begin
						// stopped timer leaves its accumulator alone
						if (ratio != 8'd0) acc_q[t_q] <= work_q;
						t_q    <= t_q + 2'd1;
						work_q <= acc_q[t_q + 2'd1] + {4'd0, mc_q};
					end else if (out_free) begin
						if (ratio != 8'd0) acc_q[t_q] <= work_q;
						t_q         <= 2'd0;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_data     = rd_q;
	assign rsp.vector_valid  = vv_q;
	assign rsp.vector_number = vec_q;
	assign rsp.irq_pending   = (pa | pb) != 8'd0;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TICK |-> !req.ready) else $error("ready during tick");
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> acc_q[0] < {8'd0, MAX_RATIO} && acc_q[3] < {8'd0, MAX_RATIO})
		else $error("prescale accumulator out of range");
	a_vec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!vv_q |-> vec_q == 8'd0) else $error("vector without valid");
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |=> state_q == ST_IDLE || t_q == 2'd0)
		else $error("tick sequencer entered mid-walk");

endmodule
